// ===== rtl/least_slack_tick_scheduler_defines.svh =====
// Assertion macros for the least slack tick scheduler.
`ifndef LEAST_SLACK_TICK_SCHEDULER_DEFINES_SVH
`define LEAST_SLACK_TICK_SCHEDULER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define LSTS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lsts assertion failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define LSTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lsts assertion failed");

`endif

// ===== rtl/lsts_pkg.sv =====
// Types, codes and helpers shared by the least slack tick scheduler.
`timescale 1ns / 1ps
`default_nettype none
package lsts_pkg;

    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_START  = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;
    localparam logic [1:0] FUNC_FINISH = 2'd3;

    localparam logic [4:0]  IDLE_CODE = 5'd31;
    localparam logic [15:0] SAT16     = 16'hFFFF;

    typedef struct packed {
        logic [15:0] compute;
        logic [15:0] period;
        logic [15:0] deadline;
    } t_task_ent;

    typedef struct packed {
        logic [15:0] rem;
        logic [16:0] absdl;
        logic        ready;
        logic [15:0] phase;
    } t_run_ent;

    typedef struct packed {
        t_run_ent           nxt;
        logic signed [18:0] slack;
        logic               work;
    } t_eval;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == SAT16) ? v : v + 16'd1;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/least_slack_tick_scheduler.sv =====
// Top level of the least slack tick scheduler: control, task memories, counters.
`timescale 1ns / 1ps
`default_nettype none
`include "least_slack_tick_scheduler_defines.svh"
// Usage:
//   A request is taken when start is high and busy is low; i_func selects load,
//   start run, tick or finish. Every request gives one result, shown for one
//   cycle with o_valid; the receiver must take it then and cannot stall it.
//   The user writes the num_tasks register over i_cfg_valid / o_cfg_ready /
//   i_cfg_data only while the block is idle (not enforced). o_cfg_ready is always high.
// Request handling:
//   load and start: result in the next cycle, busy stays low.
//   finish: the request reads the running task's run state and moves to S_FIN,
//   which registers the result; result in the next cycle when no task is running.
//   tick: a new request can be taken in the cycle the result is shown. The tick
//   walks every task entry through the run-state memory, one entry per cycle, in
//   a read / evaluate / compare pipeline that writes each in-use entry's new state
//   back, and at the end writes back the chosen task's decremented work.
// Reset:
//   Run state reads as zero until written (valid bit per entry), running task
//   is idle, counters and clock are zero, num_tasks is 1. Task tables are
//   undefined until loaded. A start request clears the run state.
module least_slack_tick_scheduler
    import lsts_pkg::*;
#(
    parameter int MAX_TASKS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [1:0]  i_func,
    input  wire  [3:0]  i_task_index,
    input  wire  [15:0] i_task_compute,
    input  wire  [15:0] i_task_period,
    input  wire  [15:0] i_task_deadline,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [4:0]  i_cfg_data,
    output logic        o_valid,
    output logic [3:0]  o_chosen_task,
    output logic        o_idle,
    output logic [15:0] o_switch_count,
    output logic [15:0] o_preempt_count
);

    localparam int TIDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);
    localparam logic [CNT_W-1:0] TASK_CNT = CNT_W'(MAX_TASKS);

    typedef enum logic [1:0] {S_IDLE, S_PASS, S_FIN} t_state;

    t_state r_state;

    t_task_ent r_tab_mem [MAX_TASKS];
    t_run_ent  r_run_mem [MAX_TASKS];
    logic [MAX_TASKS-1:0] r_run_vld;
    t_task_ent r_tab_q;
    t_run_ent  r_run_q;
    logic      r_rvld_q;

    logic [4:0]  r_num_tasks;
    logic [15:0] r_tick_clock;
    logic [4:0]  r_running;
    logic [15:0] r_switches;
    logic [15:0] r_preempts;
    logic        r_valid;

    logic [CNT_W-1:0]   r_rd_idx;
    logic               r_s1_vld;
    logic [TIDX_W-1:0]  r_s1_idx;
    logic               r_s2_vld;
    logic [TIDX_W-1:0]  r_s2_idx;
    logic signed [18:0] r_s2_slack;
    t_run_ent           r_s2_ent;
    logic               r_best_vld;
    logic [TIDX_W-1:0]  r_best_idx;
    logic signed [18:0] r_best_slack;
    t_run_ent           r_best_ent;
    logic               r_run_work;

    logic              w_acc;
    logic              tab_we;
    logic [TIDX_W-1:0] tab_waddr;
    logic              rd_en;
    logic [TIDX_W-1:0] rd_addr;
    logic              wr_en;
    logic [TIDX_W-1:0] wr_addr;
    t_run_ent          wr_data;
    t_run_ent          w_run_rd;
    t_run_ent          w_pick_ent;
    t_eval             w_ev;
    logic [5:0]        w_n_use;
    logic              w_s1_inuse;
    logic              w_done;
    logic [4:0]        w_pick;

    assign w_acc     = start && !busy;
    assign busy      = (r_state != S_IDLE);
    assign tab_we    = w_acc && (i_func == FUNC_LOAD) && (32'(i_task_index) < MAX_TASKS);
    assign tab_waddr = TIDX_W'(i_task_index);
    assign w_run_rd  = r_rvld_q ? r_run_q : '0;
    assign w_n_use   = (r_num_tasks > 5'(MAX_TASKS)) ? 6'(MAX_TASKS) : {1'b0, r_num_tasks};
    assign w_s1_inuse = (6'(r_s1_idx) < w_n_use);
    assign w_done    = (r_rd_idx == TASK_CNT) && !r_s1_vld && !r_s2_vld;
    assign w_pick    = r_best_vld ? 5'(r_best_idx) : IDLE_CODE;

    always_comb begin
        w_pick_ent       = r_best_ent;
        w_pick_ent.rem   = r_best_ent.rem - 16'd1;
        w_pick_ent.ready = (r_best_ent.rem != 16'd1);
    end

    lsts_task_eval u_eval (
        .i_tab   (r_tab_q),
        .i_run   (w_run_rd),
        .i_clock (r_tick_clock),
        .o_eval  (w_ev)
    );

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        case (r_state)
            S_IDLE: begin
                if (w_acc && (i_func == FUNC_FINISH) && (r_running != IDLE_CODE)) begin
                    rd_en   = 1'b1;
                    rd_addr = r_running[TIDX_W-1:0];
                end
            end
            S_PASS: begin
                if (r_rd_idx < TASK_CNT) begin
                    rd_en   = 1'b1;
                    rd_addr = r_rd_idx[TIDX_W-1:0];
                end
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_s1_idx;
        wr_data = w_ev.nxt;
        if (r_state == S_PASS) begin
            if (r_s1_vld && w_s1_inuse) begin
                wr_en = 1'b1;
            end else if (w_done && r_best_vld) begin
                wr_en   = 1'b1;
                wr_addr = r_best_idx;
                wr_data = w_pick_ent;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_tab_mem[tab_waddr] <= '{compute: i_task_compute, period: i_task_period,
                                      deadline: i_task_deadline};
        end
        if (wr_en) begin
            r_run_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_tab_q  <= r_tab_mem[rd_addr];
            r_run_q  <= r_run_mem[rd_addr];
            r_rvld_q <= r_run_vld[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_run_vld    <= '0;
            r_num_tasks  <= 5'd1;
            r_tick_clock <= '0;
            r_running    <= IDLE_CODE;
            r_switches   <= '0;
            r_preempts   <= '0;
            r_valid      <= 1'b0;
            r_rd_idx     <= '0;
            r_s1_vld     <= 1'b0;
            r_s2_vld     <= 1'b0;
            r_best_vld   <= 1'b0;
            r_run_work   <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_valid) begin
                r_num_tasks <= i_cfg_data;
            end
            if (wr_en) begin
                r_run_vld[wr_addr] <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    r_s1_vld <= 1'b0;
                    r_s2_vld <= 1'b0;
                    if (w_acc) begin
                        case (i_func)
                            FUNC_LOAD: begin
                                r_valid <= 1'b1;
                            end
                            FUNC_START: begin
                                r_run_vld    <= '0;
                                r_tick_clock <= '0;
                                r_running    <= IDLE_CODE;
                                r_switches   <= '0;
                                r_preempts   <= '0;
                                r_valid      <= 1'b1;
                            end
                            FUNC_TICK: begin
                                r_state    <= S_PASS;
                                r_rd_idx   <= '0;
                                r_best_vld <= 1'b0;
                                r_run_work <= 1'b0;
                            end
                            FUNC_FINISH: begin
                                if (r_running != IDLE_CODE) begin
                                    r_state <= S_FIN;
                                end else begin
                                    r_valid <= 1'b1;
                                end
                            end
                            default: begin
                                r_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                S_PASS: begin
                    r_s1_vld <= rd_en;
                    r_s1_idx <= rd_addr;
                    if (rd_en) begin
                        r_rd_idx <= r_rd_idx + 1'b1;
                    end
                    r_s2_vld   <= r_s1_vld && w_s1_inuse && w_ev.work;
                    r_s2_idx   <= r_s1_idx;
                    r_s2_slack <= w_ev.slack;
                    r_s2_ent   <= w_ev.nxt;
                    if (r_s1_vld && (5'(r_s1_idx) == r_running)) begin
                        r_run_work <= w_s1_inuse ? (w_ev.nxt.rem != 16'd0)
                                                 : (w_run_rd.rem != 16'd0);
                    end
                    if (r_s2_vld && (!r_best_vld || (r_s2_slack < r_best_slack))) begin
                        r_best_vld   <= 1'b1;
                        r_best_idx   <= r_s2_idx;
                        r_best_slack <= r_s2_slack;
                        r_best_ent   <= r_s2_ent;
                    end
                    if (w_done) begin
                        if (w_pick != r_running) begin
                            if ((r_running != IDLE_CODE) && (!r_best_vld || r_run_work)) begin
                                r_preempts <= sat_inc(r_preempts);
                            end
                            r_switches <= sat_inc(r_switches);
                            r_running  <= w_pick;
                        end
                        r_tick_clock <= sat_inc(r_tick_clock);
                        r_valid      <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                S_FIN: begin
                    if (w_run_rd.rem != 16'd0) begin
                        r_preempts <= sat_inc(r_preempts);
                    end
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_valid         = r_valid;
    assign o_idle          = (r_running == IDLE_CODE);
    assign o_chosen_task   = (r_running == IDLE_CODE) ? 4'd0 : r_running[3:0];
    assign o_switch_count  = r_switches;
    assign o_preempt_count = r_preempts;

    `LSTS_ASSERT_NOW(a_result_when_free, o_valid, !busy)
    `LSTS_ASSERT_NEXT(a_tick_goes_busy, w_acc && (i_func == FUNC_TICK), busy)
    `LSTS_ASSERT_NOW(a_best_has_work, r_best_vld, r_best_ent.rem != 16'd0)
    `LSTS_ASSERT_NOW(a_pick_written_back, (r_state == S_PASS) && w_done && r_best_vld,
                     wr_en && (wr_addr == r_best_idx))

endmodule
`default_nettype wire

// ===== rtl/lsts_task_eval.sv =====
// Per-task release update and slack computation for one tick.
`timescale 1ns / 1ps
`default_nettype none
module lsts_task_eval
    import lsts_pkg::*;
(
    input  wire t_task_ent   i_tab,
    input  wire t_run_ent    i_run,
    input  wire logic [15:0] i_clock,
    output t_eval            o_eval
);

    logic [15:0] per;
    logic [16:0] phase_inc;
    t_run_ent    nxt;

    always_comb begin
        nxt = i_run;
        if (i_run.phase == 16'd0) begin
            nxt.rem   = i_tab.compute;
            nxt.absdl = {1'b0, i_clock} + {1'b0, i_tab.deadline};
            nxt.ready = 1'b1;
        end
        per       = (i_tab.period == 16'd0) ? 16'd1 : i_tab.period;
        phase_inc = {1'b0, i_run.phase} + 17'd1;
        nxt.phase = (phase_inc >= {1'b0, per}) ? 16'd0 : phase_inc[15:0];
    end

    assign o_eval.nxt   = nxt;
    assign o_eval.slack = $signed({2'b00, nxt.absdl}) - $signed({3'b000, i_clock})
                        - $signed({3'b000, nxt.rem});
    assign o_eval.work  = nxt.ready && (nxt.rem != 16'd0);

endmodule
`default_nettype wire
